// ----- design/pie_pkg.sv -----
// pie_pkg: shared constants and types for the power iteration eigen core.
// No dependencies.
`timescale 1ns / 1ps
package pie_pkg;
	localparam logic [1:0] KIND_MAT   = 2'd0;
	localparam logic [1:0] KIND_VEC   = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
	localparam logic [1:0] REG_TOL   = 2'd0;
	localparam logic [1:0] REG_SHIFT = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [31:0] value;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] eigen_estimate;
		logic [1:0]         component_index;
		logic signed [31:0] component;
		logic [15:0]        steps;
		logic               converged;
		logic               last;
	} out_beat_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fff_ffff;
		if (v < -66'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction
endpackage

// ----- design/pie_if.sv -----
// pie_if: valid/ready channel carrying one payload beat.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
interface pie_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/pie_div.sv -----
// pie_div: radix-2 restoring divider, unsigned 64 / 32, one quotient bit per cycle.
// Depends on pie_pkg.
`timescale 1ns / 1ps
module pie_div (
	input  logic             clk,
	input  logic             arst_n,
	input  pie_pkg::div_req_t req,
	output logic             busy,
	output logic [63:0]      quot
);
	logic [63:0] q_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [6:0]  cnt_q;
	logic [32:0] trial;

	// divisor stays below 2^31, so the partial remainder fits in 32 bits
	assign trial = {rem_q, q_q[63]} - {1'b0, dsr_q};
	assign busy = cnt_q != 7'd0;
	assign quot = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q   <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], q_q[63]};
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end
endmodule

// ----- design/power_iteration_eigen_core.sv -----
// Power iteration eigen core: top level with stores, sequencer and shared MAC.
// Per step: a multiply pass of SIZE*SIZE products, a max-search pass over SIZE
// elements, SIZE divisions (skipped on a zero estimate) and one check; results then
// leave one per cycle while out_ch is ready. Not ready while a run or its output is
// in progress.
// Reset: estimates to 1.0, registers to reset values; stores undefined until written.
// Depends on pie_pkg, pie_if, pie_div.
`timescale 1ns / 1ps
module power_iteration_eigen_core #(
	parameter int SIZE = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	pie_if.sink         in_ch,
	pie_if.source       out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int IW = (SIZE > 1) ? $clog2(SIZE) : 1;
	localparam int MW = $clog2(SIZE * SIZE);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAC  = 3'd1;
	localparam logic [2:0] ST_EST  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DWT  = 3'd4;
	localparam logic [2:0] ST_CHK  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [15:0]        tol_q;
	logic signed [31:0] shift_q;
	logic [15:0]        limit_q;

	logic signed [31:0] mat_q [SIZE*SIZE];
	logic signed [31:0] vec_q [SIZE];
	logic signed [31:0] prod_q [SIZE];
	logic signed [31:0] next_q [SIZE];
	logic signed [31:0] cur_q, prev_q;
	logic [15:0]        cnt_q;
	logic               conv_q;
	logic [2:0]         state_q;
	logic [IW-1:0]      i_q, j_q;
	logic signed [65:0] acc_q;
	logic signed [31:0] a_s1, x_s1;
	logic               mv_s1;
	logic               div_busy, div_wait_q;
	logic [63:0]        div_quot;
	pie_pkg::div_req_t  dreq;
	pie_pkg::in_beat_t  ib;
	pie_pkg::out_beat_t ob;
	logic signed [63:0] mul;
	logic signed [31:0] mag, nv;
	logic [63:0]        num;
	logic signed [32:0] diff;
	logic [32:0]        adiff;
	logic [15:0]        lim;
	logic               wr;
	logic [MW-1:0]      rd_idx, wr_idx;

	assign ib = in_ch.data;
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			pie_pkg::REG_TOL:   prdata = {16'd0, tol_q};
			pie_pkg::REG_SHIFT: prdata = shift_q;
			pie_pkg::REG_LIMIT: prdata = {16'd0, limit_q};
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= 16'd1;
			shift_q <= '0;
			limit_q <= 16'd1000;
		end else if (wr && paddr[1:0] == 2'd0) begin
			unique case (paddr[3:2])
				pie_pkg::REG_TOL:   tol_q <= pwdata[15:0];
				pie_pkg::REG_SHIFT: shift_q <= pwdata;
				pie_pkg::REG_LIMIT: limit_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	assign rd_idx = MW'(i_q) * MW'(SIZE) + MW'(j_q);
	assign wr_idx = MW'(ib.row) * MW'(SIZE) + MW'(ib.col);

	// shifted matrix element times vector element
	assign mul = a_s1 * x_s1;

	assign nv = next_q[i_q];
	assign mag = (nv == 32'sh8000_0000) ? 32'sh7fff_ffff : (nv < 0 ? -nv : nv);
	assign num = {(nv < 0 ? -64'(nv) : 64'(nv))} << 16;
	assign diff = 33'(cur_q) - 33'(prev_q);
	assign adiff = diff[32] ? 33'(-diff) : 33'(diff);
	assign lim = (limit_q == 16'd0) ? 16'd1 : limit_q;

	assign dreq.start = state_q == ST_DIV && cur_q != 0;
	assign dreq.dividend = num;
	assign dreq.divisor = cur_q;

	pie_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(div_busy), .quot(div_quot));

	assign in_ch.ready = state_q == ST_IDLE;
	assign out_ch.valid = state_q == ST_OUT;
	always_comb begin
		ob.eigen_estimate  = pie_pkg::sat32(66'(cur_q) + 66'(shift_q));
		ob.component_index = 2'(i_q);
		ob.component       = prod_q[i_q];
		ob.steps           = cnt_q;
		ob.converged       = conv_q;
		ob.last            = i_q == IW'(SIZE - 1);
	end
	assign out_ch.data = ob;

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			if (ib.kind == pie_pkg::KIND_MAT && 32'(ib.row) < SIZE && 32'(ib.col) < SIZE)
				mat_q[wr_idx] <= ib.value;
			if (ib.kind == pie_pkg::KIND_VEC && 32'(ib.row) < SIZE)
				vec_q[IW'(ib.row)] <= ib.value;
			if (ib.kind == pie_pkg::KIND_START)
				for (int k = 0; k < SIZE; k++) prod_q[k] <= vec_q[k];
		end
		a_s1 <= (i_q == j_q) ? pie_pkg::sat32(66'(mat_q[rd_idx]) - 66'(shift_q))
			: mat_q[rd_idx];
		x_s1 <= prod_q[j_q];
		if (state_q == ST_DWT && !div_busy && !div_wait_q) begin
			prod_q[i_q] <= (nv < 0) ? pie_pkg::sat32(-66'(div_quot))
				: pie_pkg::sat32(66'(div_quot));
		end
		if (state_q == ST_DIV && cur_q == 0) prod_q[i_q] <= nv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q <= pie_pkg::Q_ONE;
			prev_q <= pie_pkg::Q_ONE;
			cnt_q <= '0;
			conv_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			mv_s1 <= 1'b0;
			acc_q <= '0;
			div_wait_q <= 1'b0;
		end else begin
			mv_s1 <= 1'b0;
			div_wait_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_ch.valid && ib.kind == pie_pkg::KIND_START) begin
					state_q <= ST_MAC;
					cnt_q <= 16'd1;
					prev_q <= cur_q;
					i_q <= '0;
					j_q <= '0;
					acc_q <= '0;
				end
				ST_MAC: begin
					// issue product (i,j), accumulate previous
					if (mv_s1) acc_q <= acc_q + 66'(mul >>> 16);
					mv_s1 <= 1'b1;
					if (j_q == IW'(SIZE - 1)) begin
						state_q <= ST_EST;
						j_q <= '0;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_EST: begin
					// drain last product, store row
					if (mv_s1) begin
						next_q[i_q] <= pie_pkg::sat32(acc_q + 66'(mul >>> 16));
						acc_q <= '0;
						if (i_q == IW'(SIZE - 1)) begin
							i_q <= '0;
							cur_q <= '0;
							state_q <= ST_DIV;
							j_q <= IW'(1);
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= ST_MAC;
						end
					end
				end
				ST_DIV: begin
					// first pass (j=1) finds max magnitude; second pass (j=0) divides, or copies on a zero max
					if (j_q != '0) begin
						if (mag > cur_q) cur_q <= mag;
						if (i_q == IW'(SIZE - 1)) i_q <= '0;
						else i_q <= i_q + 1'b1;
						if (i_q == IW'(SIZE - 1)) j_q <= '0;
					end else if (cur_q == 0) begin
						if (i_q == IW'(SIZE - 1)) begin
							i_q <= '0;
							state_q <= ST_CHK;
						end else i_q <= i_q + 1'b1;
					end else begin
						state_q <= ST_DWT;
						div_wait_q <= 1'b1;
					end
				end
				ST_DWT: if (!div_busy && !div_wait_q) begin
					if (i_q == IW'(SIZE - 1)) begin
						i_q <= '0;
						state_q <= ST_CHK;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_CHK: begin
					if (adiff <= 33'(tol_q)) begin
						conv_q <= 1'b1;
						state_q <= ST_OUT;
					end else if (cnt_q >= lim) begin
						conv_q <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q + 16'd1;
						prev_q <= cur_q;
						state_q <= ST_MAC;
					end
				end
				ST_OUT: if (out_ch.ready) begin
					if (i_q == IW'(SIZE - 1)) begin
						i_q <= '0;
						state_q <= ST_IDLE;
					end else i_q <= i_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
